[src/bsdf_pkg.sv]
// ----------------------------------------------------------------------------
// bsdf_pkg
// Shared types and constants of the bitmap signed distance field block.
// ----------------------------------------------------------------------------
`default_nettype none

package bsdf_pkg;

   // bitmap row geometry
   localparam int ROW_BITS = 64;
   localparam int COL_W    = 6;
   localparam int ROW_W    = 6;

   // configuration register data width
   localparam int CFG_W    = 7;

   // result byte constants
   localparam int BYTE_W   = 8;
   localparam int BYTE_SQ  = 65025;
   localparam int MID_BYTE = 127;

   // item kinds
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // configuration register indexes
   typedef enum logic [0:0] {
      CSR_WIDTH  = 1'b0,
      CSR_HEIGHT = 1'b1
   } csr_reg_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SELF,
      ST_SCAN,
      ST_MAP_INIT,
      ST_MAP_SQ,
      ST_MAP_CMP,
      ST_FINISH
   } ctl_state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic scan_start;
      logic scan_step;
      logic map_start;
      logic map_sq;
      logic map_cmp;
      logic out_load;
   } ctl_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic scan_last;
      logic map_last;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

[src/bsdf_ram.sv]
// ----------------------------------------------------------------------------
// bsdf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bsdf_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[src/bsdf_ctrl.sv]
// ----------------------------------------------------------------------------
// bsdf_ctrl
// Sequencer for one query: self pixel read, window scan, byte mapping and
// hand-off to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bsdf_ctrl
   import bsdf_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic          req_kind,
   input  wire dp_status_type status,
   output ctl_cmd_type        cmd,
   output logic               req_stall
);

   ctl_state_type state_ff;
   ctl_state_type state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && (req_kind == KIND_QUERY)) begin
               state_in = ST_SELF;
            end
         end
         ST_SELF: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.scan_last) begin
               state_in = ST_MAP_INIT;
            end
         end
         ST_MAP_INIT: begin
            state_in = ST_MAP_SQ;
         end
         ST_MAP_SQ: begin
            state_in = ST_MAP_CMP;
         end
         ST_MAP_CMP: begin
            if (status.map_last) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_MAP_SQ;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_SELF: begin
            cmd.scan_start = 1'b1;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
         end
         ST_MAP_INIT: begin
            cmd.map_start = 1'b1;
         end
         ST_MAP_SQ: begin
            cmd.map_sq = 1'b1;
         end
         ST_MAP_CMP: begin
            cmd.map_cmp = 1'b1;
         end
         ST_FINISH: begin
            cmd.out_load = status.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[src/bsdf_datapath.sv]
// ----------------------------------------------------------------------------
// bsdf_datapath
// Bitmap store, window scan unit, distance-to-byte search and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bsdf_datapath
   import bsdf_pkg::*;
#(
   parameter int MAX_SIDE      = 64,
   parameter int WINDOW_RADIUS = 10
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_accept,
   input  wire logic                req_kind,
   input  wire logic [ROW_W-1:0]    req_row_index,
   input  wire logic [COL_W-1:0]    req_column_index,
   input  wire logic [ROW_BITS-1:0] req_row_bits,
   input  wire logic                csr_write,
   input  wire logic [0:0]          csr_index,
   input  wire logic [CFG_W-1:0]    csr_wdata,
   input  wire ctl_cmd_type         cmd,
   output dp_status_type            status,
   input  wire logic                rsp_accept,
   output logic                     rsp_valid,
   output logic [BYTE_W-1:0]        rsp_distance_value,
   output logic [BYTE_W-1:0]        rsp_nearest_squared
);

   localparam int AW    = $clog2(MAX_SIDE);
   localparam int RW    = $clog2(WINDOW_RADIUS + 1);
   localparam int OW    = RW + 1;
   localparam int JW    = $clog2(ROW_BITS + WINDOW_RADIUS + 1) + 1;
   localparam int DMAX2 = 2 * WINDOW_RADIUS * WINDOW_RADIUS;
   localparam int D2W   = $clog2(DMAX2 + 1);
   localparam int SW    = $clog2(MAX_SIDE + 1);
   localparam int SQW   = 2 * BYTE_W;
   localparam int RHSW  = D2W + SQW;
   localparam int BITW  = $clog2(BYTE_W);
   localparam logic signed [OW-1:0] OFS_LO = OW'(-WINDOW_RADIUS);
   localparam logic signed [OW-1:0] OFS_HI = OW'(WINDOW_RADIUS);

   // clamp a side register to 1..MAX_SIDE
   function automatic logic [SW-1:0] clamp_side(input logic [CFG_W-1:0] v);
      logic [SW-1:0] r;
      if (v == '0) begin
         r = SW'(1);
      end else if (int'(v) > MAX_SIDE) begin
         r = SW'(MAX_SIDE);
      end else begin
         r = SW'(v);
      end
      return r;
   endfunction

   logic [CFG_W-1:0]       width_ff, width_in;
   logic [CFG_W-1:0]       height_ff, height_in;
   logic [SW-1:0]          w_eff, h_eff;

   logic [ROW_W-1:0]       q_row_ff;
   logic [COL_W-1:0]       q_col_ff;
   logic                   row_ok_ff;
   logic                   self_ff, self_in;
   logic signed [OW-1:0]   dx_ff, dx_in;
   logic signed [OW-1:0]   dy_ff, dy_in;
   logic [D2W-1:0]         best_ff, best_in;
   logic [RHSW-1:0]        rhs_ff, rhs_in;
   logic [SQW-1:0]         sq_ff, sq_in;
   logic [BYTE_W-1:0]      cnt_ff, cnt_in;
   logic [BITW-1:0]        bit_ff, bit_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]      dist_ff;
   logic [BYTE_W-1:0]      near_ff;

   logic                   query_accept;
   logic                   wr_en;
   logic                   rd_en;
   logic [AW-1:0]          rd_addr;
   logic [ROW_BITS-1:0]    rd_data;
   logic signed [OW-1:0]   fetch_dy;
   logic signed [JW-1:0]   j_fetch;
   logic signed [JW-1:0]   j_cur;
   logic signed [JW-1:0]   i_cur;
   logic                   dx_last;
   logic                   in_rows, in_cols;
   logic                   pix;
   logic [RW-1:0]          dx_mag, dy_mag;
   logic [D2W-1:0]         d2;
   logic                   hit;
   logic [BYTE_W-1:0]      cand;
   logic [BYTE_W-1:0]      t_val;
   logic [RHSW-1:0]        prod;
   logic                   pass;
   logic [BYTE_W-1:0]      byte_val;

   // configuration registers
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         case (csr_reg_type'(csr_index))
            CSR_WIDTH:  width_in  = csr_wdata;
            CSR_HEIGHT: height_in = csr_wdata;
            default: begin
               width_in = width_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CFG_W'(64);
         height_ff <= CFG_W'(64);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign w_eff = clamp_side(width_ff);
   assign h_eff = clamp_side(height_ff);

   // bitmap store: loads write at once, queries start a row read
   assign query_accept = req_accept && (req_kind == KIND_QUERY);
   assign wr_en        = req_accept && (req_kind == KIND_LOAD)
                         && (int'(req_row_index) < MAX_SIDE);

   assign dx_last  = (dx_ff == OFS_HI);
   assign fetch_dy = cmd.scan_start ? OFS_LO : (dy_ff + OW'(1));
   assign j_fetch  = JW'(q_row_ff) + JW'(fetch_dy);
   assign rd_en    = query_accept || cmd.scan_start || (cmd.scan_step && dx_last);
   assign rd_addr  = query_accept ? AW'(req_row_index) : AW'(j_fetch);

   bsdf_ram #(
      .WIDTH (ROW_BITS),
      .DEPTH (MAX_SIDE)
   ) u_rows (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(req_row_index)),
      .wr_data (req_row_bits),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // query latch
   always_ff @(posedge clock) begin
      if (query_accept) begin
         q_row_ff  <= req_row_index;
         q_col_ff  <= req_column_index;
         row_ok_ff <= (int'(req_row_index) < MAX_SIDE);
      end
   end

   // window cell compare
   assign j_cur   = JW'(q_row_ff) + JW'(dy_ff);
   assign i_cur   = JW'(q_col_ff) + JW'(dx_ff);
   assign in_rows = (int'(j_cur) >= 0) && (int'(j_cur) < int'(h_eff));
   assign in_cols = (int'(i_cur) >= 0) && (int'(i_cur) < int'(w_eff));
   assign pix     = (int'(i_cur) < ROW_BITS) ? rd_data[i_cur[COL_W-1:0]] : 1'b0;
   assign dx_mag  = dx_ff[OW-1] ? RW'(-dx_ff) : RW'(dx_ff);
   assign dy_mag  = dy_ff[OW-1] ? RW'(-dy_ff) : RW'(dy_ff);
   assign d2      = (D2W'(dx_mag) * D2W'(dx_mag)) + (D2W'(dy_mag) * D2W'(dy_mag));
   assign hit     = in_rows && in_cols && (pix != self_ff) && (d2 < best_ff);

   // byte search: count of odd t = 2u+1 passing the bound
   // a count of 128 is the top, larger candidates would wrap t
   assign cand     = cnt_ff | (BYTE_W'(1) << bit_ff);
   assign t_val    = {cand[BYTE_W-2:0], 1'b0} - BYTE_W'(1);
   assign prod     = RHSW'(sq_ff) * RHSW'(DMAX2);
   assign pass     = !cnt_ff[BYTE_W-1]
                     && (self_ff ? (prod <= rhs_ff) : (prod < rhs_ff));
   assign byte_val = self_ff ? (BYTE_W'(MID_BYTE) + cnt_ff)
                             : (BYTE_W'(MID_BYTE) - cnt_ff);

   // scan and search next values
   always_comb begin
      self_in = self_ff;
      dx_in   = dx_ff;
      dy_in   = dy_ff;
      best_in = best_ff;
      rhs_in  = rhs_ff;
      sq_in   = sq_ff;
      cnt_in  = cnt_ff;
      bit_in  = bit_ff;
      if (cmd.scan_start) begin
         self_in = row_ok_ff && rd_data[q_col_ff];
         dx_in   = OFS_LO;
         dy_in   = OFS_LO;
         best_in = D2W'(DMAX2);
      end
      if (cmd.scan_step) begin
         if (hit) begin
            best_in = d2;
         end
         if (dx_last) begin
            dx_in = OFS_LO;
            dy_in = dy_ff + OW'(1);
         end else begin
            dx_in = dx_ff + OW'(1);
         end
      end
      if (cmd.map_start) begin
         rhs_in = RHSW'(best_ff) * RHSW'(BYTE_SQ);
         cnt_in = '0;
         bit_in = BITW'(BYTE_W - 1);
      end
      if (cmd.map_sq) begin
         sq_in = SQW'(t_val) * SQW'(t_val);
      end
      if (cmd.map_cmp) begin
         if (pass) begin
            cnt_in = cand;
         end
         bit_in = bit_ff - BITW'(1);
      end
   end

   always_ff @(posedge clock) begin
      self_ff <= self_in;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      best_ff <= best_in;
      rhs_ff  <= rhs_in;
      sq_ff   <= sq_in;
      cnt_ff  <= cnt_in;
      bit_ff  <= bit_in;
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_accept) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         dist_ff <= byte_val;
         near_ff <= BYTE_W'(best_ff);
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_distance_value  = dist_ff;
   assign rsp_nearest_squared = near_ff;

   // status to controller
   assign status.scan_last = dx_last && (dy_ff == OFS_HI);
   assign status.map_last  = (bit_ff == '0);
   assign status.out_free  = !rsp_valid_ff || rsp_accept;

endmodule

`default_nettype wire

[src/bitmap_signed_distance_field_top.sv]
// ----------------------------------------------------------------------------
// bitmap_signed_distance_field_top
// Signed distance byte of one pixel of a loaded one-bit bitmap.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: a beat with kind = load writes row_bits into row row_index
//   and finishes in the accept cycle; no rsp beat follows. A beat with
//   kind = query names one pixel and gives exactly one rsp beat.
//   rsp channel: distance byte and least squared distance of the query.
//   csr channel: always ready, writes bitmap width (index 0) or height
//   (index 1); user writes it only while no query is in flight (not enforced).
// Sequence:
//   a query runs a self-pixel read, a scan of the (2*WINDOW_RADIUS+1)^2
//   window cells (one window cell per cycle), one setup step, the byte
//   search (a square step and a compare step per result bit) and a
//   hand-off to the output register. req_stall is high for the whole
//   query; while the block is idle, loads are taken without stall.
// Reset: synchronous, clears the controller, the rsp valid and the csr
//   registers (64 by 64); bitmap rows are undefined until loaded.
// Stalls: a finished result waits in the output register; the next load
//   or query is still taken, a later query holds until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_signed_distance_field_top
   import bsdf_pkg::*;
#(
   parameter int MAX_SIDE      = 64,
   parameter int WINDOW_RADIUS = 10
) (
   input  wire logic                clock,
   input  wire logic                reset,
   // request channel
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic                req_kind,
   input  wire logic [ROW_W-1:0]    req_row_index,
   input  wire logic [COL_W-1:0]    req_column_index,
   input  wire logic [ROW_BITS-1:0] req_row_bits,
   // response channel
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [BYTE_W-1:0]        rsp_distance_value,
   output logic [BYTE_W-1:0]        rsp_nearest_squared,
   // configuration channel
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [0:0]          csr_index,
   input  wire logic [CFG_W-1:0]    csr_wdata
);

   ctl_cmd_type   cmd;
   dp_status_type status;
   logic          req_accept;
   logic          rsp_accept;
   logic          csr_write;

   // beat handshakes
   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;

   bsdf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .status    (status),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   bsdf_datapath #(
      .MAX_SIDE      (MAX_SIDE),
      .WINDOW_RADIUS (WINDOW_RADIUS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .req_accept          (req_accept),
      .req_kind            (req_kind),
      .req_row_index       (req_row_index),
      .req_column_index    (req_column_index),
      .req_row_bits        (req_row_bits),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .cmd                 (cmd),
      .status              (status),
      .rsp_accept          (rsp_accept),
      .rsp_valid           (rsp_valid),
      .rsp_distance_value  (rsp_distance_value),
      .rsp_nearest_squared (rsp_nearest_squared)
   );

   // a query beat makes the block busy in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_kind == KIND_QUERY)) |=> req_stall)
      else $error("query accepted but block not busy");

   // a new result only appears out of a busy cycle
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without a query in flight");

   // no opposite pixel found exactly when the byte saturates
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (2 * WINDOW_RADIUS * WINDOW_RADIUS < 256)) |->
      ((rsp_nearest_squared == BYTE_W'(2 * WINDOW_RADIUS * WINDOW_RADIUS)) ==
       ((rsp_distance_value == 8'd0) || (rsp_distance_value == 8'd255))))
      else $error("distance byte disagrees with nearest distance");

endmodule

`default_nettype wire
